// ===== design/ggh_pkg.sv =====
`default_nettype none
package ggh_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN        = 24;
  localparam int CW               = 52;   // CORDIC x/y datapath
  localparam int ZW               = 24;   // angles, 1/2^20 rad
  localparam int QUEUE_DEPTH      = 2;

  localparam logic signed [24:0]   ANG_PI      = 25'sd3294199;
  localparam logic signed [24:0]   ANG_TWO_PI  = 25'sd6588398;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 24'sd1647099;

  localparam logic [15:0] ARRIVE_RADIUS_RST     = 16'd410;
  localparam logic [14:0] HEADING_TOLERANCE_RST = 15'd819;
  localparam logic [15:0] TURN_GAIN_RST         = 16'd19661;
  localparam logic [15:0] CRUISE_SPEED_RST      = 16'd1229;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SET_GOAL = 2'd1,
    OP_HALT     = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    REG_ARRIVE_RADIUS     = 2'd0,
    REG_HEADING_TOLERANCE = 2'd1,
    REG_TURN_GAIN         = 2'd2,
    REG_CRUISE_SPEED      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    K_TICK,
    K_GOAL,
    K_HALT
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_CHK,
    S_YAW,
    S_BEAR,
    S_WRAP,
    S_ERR,
    S_RATE,
    S_EMIT
  } back_state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        linear_speed;
    logic signed [15:0] angular_rate;
    logic               finished;
  } out_word_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } q_entry_t;

  typedef struct packed {
    logic [15:0] arrive_radius;
    logic [14:0] heading_tolerance;
    logic [15:0] turn_gain;
    logic [15:0] cruise_speed;
  } cfg_t;

  // atan(2^-i) in 1/2^20 rad, rounded
  function automatic logic [19:0] atan_entry(input logic [4:0] i);
    logic [19:0] v;
    case (i)
      5'd0:    v = 20'd823550;
      5'd1:    v = 20'd486170;
      5'd2:    v = 20'd256879;
      5'd3:    v = 20'd130396;
      5'd4:    v = 20'd65451;
      5'd5:    v = 20'd32757;
      5'd6:    v = 20'd16383;
      5'd7:    v = 20'd8192;
      5'd8:    v = 20'd4096;
      5'd9:    v = 20'd2048;
      5'd10:   v = 20'd1024;
      5'd11:   v = 20'd512;
      5'd12:   v = 20'd256;
      5'd13:   v = 20'd128;
      5'd14:   v = 20'd64;
      5'd15:   v = 20'd32;
      5'd16:   v = 20'd16;
      5'd17:   v = 20'd8;
      5'd18:   v = 20'd4;
      5'd19:   v = 20'd2;
      5'd20:   v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/ggh_front.sv =====
`default_nettype none
module ggh_front import ggh_pkg::*; (
  input  logic     cmd_valid,
  input  in_word_t cmd,
  input  logic     q_full,
  output logic     cmd_stall,
  output logic     push,
  output q_entry_t entry
);

  logic  known;
  kind_t kind;

  always_comb begin
    known = 1'b1;
    kind  = K_TICK;
    unique case (cmd.opcode)
      OP_TICK:     kind = K_TICK;
      OP_SET_GOAL: kind = K_GOAL;
      OP_HALT:     kind = K_HALT;
      default:     known = 1'b0;
    endcase
  end

  // take unknown opcodes and drop them
  assign cmd_stall = q_full;
  assign push      = cmd_valid && !q_full && known;

  assign entry.kind   = kind;
  assign entry.pos_x  = cmd.pos_x;
  assign entry.pos_y  = cmd.pos_y;
  assign entry.quat_x = cmd.quat_x;
  assign entry.quat_y = cmd.quat_y;
  assign entry.quat_z = cmd.quat_z;
  assign entry.quat_w = cmd.quat_w;

endmodule
`default_nettype wire

// ===== design/ggh_queue.sv =====
`default_nettype none
module ggh_queue import ggh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t wr_entry,
  input  logic     pop,
  output logic     valid,
  output logic     full,
  output q_entry_t rd_entry
);

  q_entry_t   slots [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (!push && pop) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  assign valid    = (count != 2'd0);
  assign full     = (count == 2'(QUEUE_DEPTH));
  assign rd_entry = slots[rd_ptr];

endmodule
`default_nettype wire

// ===== design/ggh_cordic.sv =====
`default_nettype none
module ggh_cordic import ggh_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [CW-1:0] vx,
  input  logic signed [CW-1:0] vy,
  output logic signed [ZW-1:0] angle,
  output logic                 done
);

  localparam int ITERS = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;
  localparam logic [4:0] LAST = 5'(ITERS);

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic [4:0]           it;
  logic                 busy;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] step_ang;

  assign xs       = x >>> it;
  assign ys       = y >>> it;
  assign step_ang = $signed({{(ZW-20){1'b0}}, atan_entry(it)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      it   <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        // zero vector: skip the iterations, angle stays 0
        it   <= (vx == '0 && vy == '0) ? LAST : 5'd0;
      end else if (busy) begin
        if (it == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          it <= it + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (vx < 0) begin
        if (vy >= 0) begin
          x <= vy;
          y <= -vx;
          z <= ANG_HALF_PI;
        end else begin
          x <= -vy;
          y <= vx;
          z <= -ANG_HALF_PI;
        end
      end else begin
        x <= vx;
        y <= vy;
        z <= '0;
      end
    end else if (busy && it != LAST) begin
      if (y >= 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + step_ang;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - step_ang;
      end
    end
  end

  assign angle = z;

endmodule
`default_nettype wire

// ===== design/ggh_back.sv =====
`default_nettype none
module ggh_back import ggh_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  q_entry_t  q_entry,
  output logic      q_pop,
  output out_word_t res,
  output logic      res_valid,
  input  logic      res_stall
);

  // multiply sequence
  localparam logic [3:0] P_DXX = 4'd0;
  localparam logic [3:0] P_DYY = 4'd1;
  localparam logic [3:0] P_RR  = 4'd2;
  localparam logic [3:0] P_XX  = 4'd3;
  localparam logic [3:0] P_YY  = 4'd4;
  localparam logic [3:0] P_ZZ  = 4'd5;
  localparam logic [3:0] P_WW  = 4'd6;
  localparam logic [3:0] P_XZ  = 4'd7;
  localparam logic [3:0] P_WY  = 4'd8;
  localparam logic [3:0] P_XY  = 4'd9;
  localparam logic [3:0] P_WZ  = 4'd10;
  localparam logic [3:0] P_END = 4'd11;

  back_state_t state, state_next;

  logic               armed;
  logic signed [23:0] goal_x;
  logic signed [23:0] goal_y;
  logic signed [24:0] dx;
  logic signed [24:0] dy;
  logic signed [15:0] qx, qy, qz, qw;
  logic [3:0]         step;
  logic [3:0]         pidx;
  logic signed [49:0] p;
  logic [50:0]        d2;
  logic [31:0]        r2;
  logic [33:0]        norm;
  logic signed [33:0] den;
  logic signed [33:0] m20;
  logic signed [33:0] num;
  logic signed [ZW-1:0] yaw;
  logic signed [24:0] err;
  logic signed [17:0] e13;
  out_word_t          pend;

  logic               c_start;
  logic               sel_bear;
  logic               res_load;
  logic               arrived;
  logic               yaw_skip;
  logic               turn;
  logic signed [CW-1:0] c_vx, c_vy;
  logic signed [ZW-1:0] c_z;
  logic               c_done;
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod;
  logic [33:0]        m20_abs;
  logic signed [24:0] wrapped;
  logic signed [24:0] wsum;
  logic [17:0]        e13_abs;
  logic signed [49:0] rate_sum;

  assign arrived  = d2 < {19'd0, r2};
  assign m20_abs  = m20[33] ? 34'(-m20) : 34'(m20);
  assign yaw_skip = {m20_abs, 1'b0} >= {1'b0, norm};
  assign e13_abs  = e13[17] ? 18'(-e13) : 18'(e13);
  assign turn     = e13_abs > {3'd0, cfg.heading_tolerance};

  always_comb begin
    if (err > ANG_PI)        wrapped = err - ANG_TWO_PI;
    else if (err <= -ANG_PI) wrapped = err + ANG_TWO_PI;
    else                     wrapped = err;
    wsum     = wrapped + 25'sd64;
    rate_sum = p + 50'sd32768;
  end

  always_comb begin
    mul_a = dx;
    mul_b = dx;
    if (state == S_ERR) begin
      mul_a = {{7{e13[17]}}, e13};
      mul_b = $signed({9'd0, cfg.turn_gain});
    end else begin
      unique case (step)
        P_DXX: begin mul_a = dx; mul_b = dx; end
        P_DYY: begin mul_a = dy; mul_b = dy; end
        P_RR: begin
          mul_a = $signed({9'd0, cfg.arrive_radius});
          mul_b = $signed({9'd0, cfg.arrive_radius});
        end
        P_XX: begin mul_a = {{9{qx[15]}}, qx}; mul_b = {{9{qx[15]}}, qx}; end
        P_YY: begin mul_a = {{9{qy[15]}}, qy}; mul_b = {{9{qy[15]}}, qy}; end
        P_ZZ: begin mul_a = {{9{qz[15]}}, qz}; mul_b = {{9{qz[15]}}, qz}; end
        P_WW: begin mul_a = {{9{qw[15]}}, qw}; mul_b = {{9{qw[15]}}, qw}; end
        P_XZ: begin mul_a = {{9{qx[15]}}, qx}; mul_b = {{9{qz[15]}}, qz}; end
        P_WY: begin mul_a = {{9{qw[15]}}, qw}; mul_b = {{9{qy[15]}}, qy}; end
        P_XY: begin mul_a = {{9{qx[15]}}, qx}; mul_b = {{9{qy[15]}}, qy}; end
        P_WZ: begin mul_a = {{9{qw[15]}}, qw}; mul_b = {{9{qz[15]}}, qz}; end
        default: begin mul_a = dx; mul_b = dx; end
      endcase
    end
  end

  assign prod = mul_a * mul_b;

  // yaw from (2(xy+wz), w2+x2-y2-z2) scaled by 2^14, bearing from (dy, dx) by 2^20
  always_comb begin
    if (sel_bear) begin
      c_vy = {{(CW-45){dy[24]}}, dy, 20'd0};
      c_vx = {{(CW-45){dx[24]}}, dx, 20'd0};
    end else begin
      c_vy = {{(CW-49){num[33]}}, num, 15'd0};
      c_vx = {{(CW-48){den[33]}}, den, 14'd0};
    end
  end

  ggh_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .vx    (c_vx),
    .vy    (c_vy),
    .angle (c_z),
    .done  (c_done)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    c_start    = 1'b0;
    sel_bear   = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_entry.kind)
            K_HALT:  state_next = S_EMIT;
            K_TICK:  state_next = armed ? S_MUL : S_IDLE;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        if (step == P_END) state_next = S_CHK;
      end
      S_CHK: begin
        if (arrived) begin
          state_next = S_EMIT;
        end else if (yaw_skip) begin
          c_start    = 1'b1;
          sel_bear   = 1'b1;
          state_next = S_BEAR;
        end else begin
          c_start    = 1'b1;
          state_next = S_YAW;
        end
      end
      S_YAW: begin
        if (c_done) begin
          c_start    = 1'b1;
          sel_bear   = 1'b1;
          state_next = S_BEAR;
        end
      end
      S_BEAR: begin
        if (c_done) state_next = S_WRAP;
      end
      S_WRAP: state_next = S_ERR;
      S_ERR:  state_next = turn ? S_RATE : S_EMIT;
      S_RATE: state_next = S_EMIT;
      S_EMIT: begin
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      goal_x    <= '0;
      goal_y    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (q_pop && q_entry.kind == K_GOAL) begin
        goal_x <= q_entry.pos_x;
        goal_y <= q_entry.pos_y;
        armed  <= 1'b1;
      end else if (q_pop && q_entry.kind == K_HALT) begin
        armed <= 1'b0;
      end else if (state == S_CHK && arrived) begin
        armed <= 1'b0;
      end
      if (res_load)       res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) res <= pend;
    unique case (state)
      S_IDLE: begin
        step <= P_DXX;
        pend <= '0;
        dx   <= {goal_x[23], goal_x} - {q_entry.pos_x[23], q_entry.pos_x};
        dy   <= {goal_y[23], goal_y} - {q_entry.pos_y[23], q_entry.pos_y};
        qx   <= q_entry.quat_x;
        qy   <= q_entry.quat_y;
        qz   <= q_entry.quat_z;
        qw   <= q_entry.quat_w;
      end
      S_MUL: begin
        step <= step + 4'd1;
        pidx <= step;
        p    <= prod;
        // fold in the registered product of the previous step
        if (step != P_DXX) begin
          unique case (pidx)
            P_DXX: d2 <= {1'b0, p};
            P_DYY: d2 <= d2 + {1'b0, p};
            P_RR:  r2 <= p[31:0];
            P_XX: begin norm <= p[33:0];        den <= p[33:0];       end
            P_YY: begin norm <= norm + p[33:0]; den <= den - p[33:0]; end
            P_ZZ: begin norm <= norm + p[33:0]; den <= den - p[33:0]; end
            P_WW: begin norm <= norm + p[33:0]; den <= den + p[33:0]; end
            P_XZ: m20 <= p[33:0];
            P_WY: m20 <= m20 - p[33:0];
            P_XY: num <= p[33:0];
            P_WZ: num <= num + p[33:0];
            default: ;
          endcase
        end
      end
      S_CHK: begin
        pend.finished <= arrived;
        yaw           <= '0;
      end
      S_YAW: begin
        if (c_done) yaw <= c_z;
      end
      S_BEAR: begin
        if (c_done) err <= {c_z[ZW-1], c_z} - {yaw[ZW-1], yaw};
      end
      S_WRAP: e13 <= wsum[24:7];
      S_ERR: begin
        p <= prod;
        if (!turn) pend.linear_speed <= cfg.cruise_speed;
      end
      S_RATE: pend.angular_rate <= rate_sum[31:16];
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE)
    else $error("queue popped outside idle");

  a_goal_arms: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_entry.kind == K_GOAL) |=> armed)
    else $error("set goal did not arm");

  a_finish_stop: assert property (@(posedge clk) disable iff (rst)
    (res_load && pend.finished) |-> (pend.linear_speed == '0 && pend.angular_rate == '0))
    else $error("finished word carries nonzero velocity");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!res_valid || !res_stall))
    else $error("result overwritten while held");
`endif

endmodule
`default_nettype wire

// ===== design/go_to_goal_heading_controller.sv =====
`default_nettype none
// Tick: from queue to result word through the shared 25x25 multiplier sequence
// and up to two passes of one CORDIC unit (yaw, then bearing).
// Halt gives a result word; set goal gives none. One item in work at a time;
// a 2-word queue and the output register let input and output stall apart.
// Synchronous active-high reset: disarmed, goal at origin, registers at defaults.
module go_to_goal_heading_controller import ggh_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  in_word_t    cmd,
  output logic        res_valid,
  input  logic        res_stall,
  output out_word_t   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  logic     q_full, q_valid, q_push, q_pop;
  q_entry_t q_wr, q_rd;
  reg_idx_t ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arrive_radius     <= ARRIVE_RADIUS_RST;
      cfg.heading_tolerance <= HEADING_TOLERANCE_RST;
      cfg.turn_gain         <= TURN_GAIN_RST;
      cfg.cruise_speed      <= CRUISE_SPEED_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (ridx)
        REG_ARRIVE_RADIUS:     cfg.arrive_radius     <= pwdata[15:0];
        REG_HEADING_TOLERANCE: cfg.heading_tolerance <= pwdata[14:0];
        REG_TURN_GAIN:         cfg.turn_gain         <= pwdata[15:0];
        REG_CRUISE_SPEED:      cfg.cruise_speed      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ARRIVE_RADIUS:     prdata = {16'd0, cfg.arrive_radius};
      REG_HEADING_TOLERANCE: prdata = {17'd0, cfg.heading_tolerance};
      REG_TURN_GAIN:         prdata = {16'd0, cfg.turn_gain};
      REG_CRUISE_SPEED:      prdata = {16'd0, cfg.cruise_speed};
      default:               prdata = 32'd0;
    endcase
  end

  ggh_front u_front (
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .q_full    (q_full),
    .cmd_stall (cmd_stall),
    .push      (q_push),
    .entry     (q_wr)
  );

  ggh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr),
    .pop      (q_pop),
    .valid    (q_valid),
    .full     (q_full),
    .rd_entry (q_rd)
  );

  ggh_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (q_rd),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_stall (res_stall)
  );

endmodule
`default_nettype wire

// ===== test/tb_go_to_goal_heading_controller.sv =====
`timescale 1ns / 100ps
module tb_go_to_goal_heading_controller;
  import ggh_pkg::*;

  localparam int STEPS = 16;
  localparam int SETTLE = 80;
  localparam longint ATAN_TAB [0:15] = '{823550, 486170, 256879, 130396, 65451, 32757,
                                         16383, 8192, 4096, 2048, 1024, 512, 256, 128,
                                         64, 32};
  localparam longint HALF_PI = 1647099;
  localparam longint PI_20 = 3294199;
  localparam longint TWO_PI_20 = 6588398;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  in_word_t    cmd = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  out_word_t   res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  go_to_goal_heading_controller uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [15:0]        radius_q = ARRIVE_RADIUS_RST;
  logic [14:0]        tolerance_q = HEADING_TOLERANCE_RST;
  logic [15:0]        gain_q = TURN_GAIN_RST;
  logic [15:0]        cruise_q = CRUISE_SPEED_RST;
  logic signed [23:0] goal_x_q = '0;
  logic signed [23:0] goal_y_q = '0;
  logic               armed_q = 1'b0;

  in_word_t  pending_cmds[$];
  out_word_t expected_cmds[$];
  int        mismatches = 0;

  function automatic void queue_word(in_word_t w);
    pending_cmds = {pending_cmds, w};
  endfunction

  function automatic void expect_word(out_word_t o);
    expected_cmds = {expected_cmds, o};
  endfunction

  task automatic flag(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic longint heading_atan2(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  // advance controller state for one accepted word, queue the command it causes
  function automatic void predict_command(in_word_t w);
    longint dx, dy, d2, r2, qx, qy, qz, qw, norm, m20, yaw, bearing, err, e13, rate;
    out_word_t o;
    o = '0;
    if (w.opcode == OP_SET_GOAL) begin
      goal_x_q = w.pos_x;
      goal_y_q = w.pos_y;
      armed_q = 1'b1;
      return;
    end
    if (w.opcode == OP_HALT) begin
      armed_q = 1'b0;
      expect_word(o);
      return;
    end
    if (w.opcode != OP_TICK || !armed_q) return;
    dx = longint'(goal_x_q) - longint'(w.pos_x);
    dy = longint'(goal_y_q) - longint'(w.pos_y);
    d2 = dx * dx + dy * dy;
    r2 = longint'(radius_q) * longint'(radius_q);
    if (d2 < r2) begin
      armed_q = 1'b0;
      o.finished = 1'b1;
      expect_word(o);
      return;
    end
    qx = w.quat_x; qy = w.quat_y; qz = w.quat_z; qw = w.quat_w;
    norm = qx * qx + qy * qy + qz * qz + qw * qw;
    m20 = 2 * (qx * qz - qw * qy);
    if (m20 < 0) m20 = -m20;
    if (m20 >= norm) yaw = 0;
    else yaw = heading_atan2(2 * (qx * qy + qw * qz) * 16384,
                             (qw * qw + qx * qx - qy * qy - qz * qz) * 16384);
    bearing = heading_atan2(dy * 1048576, dx * 1048576);
    err = bearing - yaw;
    if (err > PI_20) err -= TWO_PI_20;
    else if (err <= -PI_20) err += TWO_PI_20;
    e13 = (err + 64) >>> 7;
    if ((e13 < 0 ? -e13 : e13) > longint'(tolerance_q)) begin
      rate = (e13 * longint'(gain_q) + 32768) >>> 16;
      o.angular_rate = rate[15:0];
    end else begin
      o.linear_speed = cruise_q;
    end
    expect_word(o);
  endfunction

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (cmd_valid && !cmd_stall) predict_command(pending_cmds.pop_front());
      if (cmd_valid && cmd_stall) begin
        // hold the stalled word
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        cmd_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cmd <= pending_cmds[0];
        cmd_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes each time the 6-bit counter wraps, plus one long hold
  logic [5:0] rx_count = '0;
  int         rx_mode = 0;
  int         hold_left = 0;
  logic       hold_req = 1'b0;
  logic       hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      rx_count <= rx_count + 1'b1;
      if (rx_count == 0) rx_mode <= $urandom_range(0, 2);
      if (hold_req && !hold_done) begin
        hold_left <= 400;
        hold_done <= 1'b1;
        res_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_stall <= 1'b1;
      end else begin
        case (rx_mode)
          0: res_stall <= 1'b0;
          1: res_stall <= ($urandom_range(0, 3) == 0);
          default: res_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // checker
  out_word_t want;
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_cmds.size() == 0) begin
        flag("command with none pending, linear_speed", res.linear_speed, 0);
      end else begin
        want = expected_cmds.pop_front();
        if (res.linear_speed !== want.linear_speed)
          flag("linear_speed", res.linear_speed, want.linear_speed);
        if (res.angular_rate !== want.angular_rate)
          flag("angular_rate", res.angular_rate, want.angular_rate);
        if (res.finished !== want.finished)
          flag("finished", res.finished, want.finished);
      end
    end
  end

  function automatic in_word_t word(logic [1:0] op, int px, int py,
                                    int qx, int qy, int qz, int qw);
    in_word_t w;
    w.opcode = op;
    w.pos_x = px[23:0];
    w.pos_y = py[23:0];
    w.quat_x = qx[15:0];
    w.quat_y = qy[15:0];
    w.quat_z = qz[15:0];
    w.quat_w = qw[15:0];
    return w;
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ARRIVE_RADIUS:     radius_q = value[15:0];
      REG_HEADING_TOLERANCE: tolerance_q = value[14:0];
      REG_TURN_GAIN:         gain_q = value[15:0];
      REG_CRUISE_SPEED:      cruise_q = value[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || cmd_valid || expected_cmds.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_all(int r, int t, int g, int c);
    reg_write(REG_ARRIVE_RADIUS, r);
    reg_write(REG_HEADING_TOLERANCE, t);
    reg_write(REG_TURN_GAIN, g);
    reg_write(REG_CRUISE_SPEED, c);
    @(negedge clk);
  endtask

  function automatic int rnd16();
    return int'($urandom_range(0, 65535));
  endfunction

  function automatic int rnd24();
    return int'($urandom_range(0, 24'hFFFFFF));
  endfunction

  // a goal, then mostly ticks around it; some noise
  task automatic random_words(int count);
    int r, gx, gy, ox, oy, span, z, w;
    gx = $signed(24'(rnd24())) / 64;
    gy = $signed(24'(rnd24())) / 64;
    queue_word(word(OP_SET_GOAL, gx, gy, rnd16(), rnd16(), rnd16(), rnd16()));
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        gx = ($urandom_range(0, 4) == 0) ? rnd24() : $signed(24'(rnd24())) / 64;
        gy = ($urandom_range(0, 4) == 0) ? rnd24() : $signed(24'(rnd24())) / 64;
        queue_word(word(OP_SET_GOAL, gx, gy, rnd16(), rnd16(), rnd16(), rnd16()));
      end else if (r < 10) begin
        queue_word(word(OP_HALT, rnd24(), rnd24(), rnd16(), rnd16(), rnd16(), rnd16()));
        queue_word(word(OP_SET_GOAL, gx, gy, 0, 0, 0, 16384));
      end else if (r < 12) begin
        queue_word(word(2'd3, rnd24(), rnd24(), rnd16(), rnd16(), rnd16(), rnd16()));
      end else if (r < 18) begin
        queue_word(word(OP_TICK, rnd24(), rnd24(), rnd16(), rnd16(), rnd16(), rnd16()));
      end else begin
        case ($urandom_range(0, 3))
          0: span = radius_q + 4;
          1: span = 2000;
          2: span = 100000;
          default: span = 4000000;
        endcase
        ox = int'($urandom_range(0, 2 * span)) - span;
        oy = int'($urandom_range(0, 2 * span)) - span;
        z = $signed(16'(rnd16())) / 2;
        w = $signed(16'(rnd16())) / 2;
        if ($urandom_range(0, 2) == 0)
          queue_word(word(OP_TICK, gx - ox, gy - oy, rnd16(), rnd16(), rnd16(), rnd16()));
        else
          queue_word(word(OP_TICK, gx - ox, gy - oy, 0, 0, z, w));
        // re-arm after a likely arrival
        if (span == radius_q + 4 && $urandom_range(0, 9) < 7)
          queue_word(word(OP_SET_GOAL, gx, gy, 0, 0, 0, 0));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset settings
    queue_word(word(OP_TICK, 100, 100, 0, 0, 0, 16384));
    queue_word(word(OP_HALT, 0, 0, 0, 0, 0, 0));
    queue_word(word(OP_HALT, 0, 0, 0, 0, 0, 0));
    queue_word(word(2'd3, -1, -1, -1, -1, -1, -1));
    queue_word(word(OP_SET_GOAL, 8388607, 8388607, 0, 0, 0, 0));
    queue_word(word(OP_SET_GOAL, -8388608, 8388607, 0, 0, 0, 0));
    queue_word(word(OP_TICK, 8388607, -8388608, 0, 0, 0, 0));
    queue_word(word(OP_TICK, 8388607, -8388608, 0, 16384, 0, 16384));
    queue_word(word(OP_TICK, 0, 0, -32768, -32768, -32768, -32768));
    queue_word(word(OP_TICK, 0, 0, 32767, 32767, 32767, 32767));
    queue_word(word(OP_TICK, -8388608, 0, 0, 0, 32767, -32768));
    queue_word(word(OP_TICK, -8388608, 8388500, 0, 0, 11585, 11585));
    queue_word(word(OP_TICK, -8388608, 8388607, 0, 0, 0, 16384));
    queue_word(word(OP_SET_GOAL, 0, 0, 0, 0, 0, 0));
    queue_word(word(OP_TICK, -200, 0, 0, 0, 0, -16384));
    queue_word(word(OP_TICK, 409, 0, 0, 0, 0, 16384));
    queue_word(word(OP_TICK, 1000, 1000, 0, 0, 0, 16384));
    drain();

    // extremes: zero radius, zero tolerance, full gain and speed
    set_all(0, 0, 65535, 65535);
    queue_word(word(OP_SET_GOAL, 5000, -5000, 0, 0, 0, 0));
    queue_word(word(OP_TICK, 5000, -5000, 0, 0, 16384, 16384));
    queue_word(word(OP_TICK, 5001, -5000, 0, 0, 16384, -16384));
    queue_word(word(OP_TICK, 5000, -5000, 0, 0, 0, 16384));
    random_words(80);
    drain();

    set_all(65535, 25736, 0, 0);
    random_words(80);
    drain();

    set_all(32767, 32767, 65535, 1);
    random_words(80);
    hold_req = 1'b1;
    drain();

    for (int p = 0; p < 3; p++) begin
      set_all($urandom_range(0, 3000), $urandom_range(0, 25736), rnd16(), rnd16());
      random_words(80);
      drain();
    end

    set_all(ARRIVE_RADIUS_RST, HEADING_TOLERANCE_RST, TURN_GAIN_RST, CRUISE_SPEED_RST);
    random_words(40);
    drain();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
